// ----- design/shape_pair_overlap_push_assert.svh -----
// Assertion macros for the shape pair overlap and push block.
`ifndef SHAPE_PAIR_OVERLAP_PUSH_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_PUSH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPOP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/spop_pkg.sv -----
// Package with widths, beat types and helpers for the shape pair overlap block.
package spop_pkg;

    localparam int CW         = 32;
    localparam int HW         = CW - 1;
    localparam int MW         = CW + 1;
    localparam int DW         = CW + 2;
    localparam int SQW        = 2 * CW;
    localparam int D2W        = 2 * CW + 2;
    localparam int RW         = CW + 3;
    localparam int SQ_STAGES  = CW;
    localparam int DIV_STAGES = CW;

    localparam logic [CW-1:0] SIGN_BIT = {1'b1, {(CW-1){1'b0}}};

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SHAPE = 2'd1;
    localparam logic [1:0] CMD_POINT = 2'd2;

    typedef enum logic [2:0] {
        KIND_PT_BOX    = 3'd0,
        KIND_PT_SPH    = 3'd1,
        KIND_BB        = 3'd2,
        KIND_SS        = 3'd3,
        KIND_RBOX_TSPH = 3'd4,
        KIND_RSPH_TBOX = 3'd5
    } t_kind;

    typedef struct packed {
        logic [1:0]           cmd;
        logic                 shape_is_sphere;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_z;
        logic [HW-1:0]        half_x;
        logic [HW-1:0]        half_y;
        logic [HW-1:0]        half_z;
        logic                 want_push;
    } t_in_beat;

    typedef struct packed {
        logic                 hit;
        logic                 push_valid;
        logic signed [CW-1:0] push_x;
        logic signed [CW-1:0] push_y;
        logic signed [CW-1:0] push_z;
    } t_out_beat;

    typedef struct packed {
        t_kind kind;
        logic  want;
        logic  coinc;
        logic  negate;
    } t_ctl;

    typedef struct packed {
        logic                 hit;
        logic                 pv;
        logic                 sph;
        logic                 coinc;
        logic                 negate;
        logic [2:0]           neg;
        logic [2:0][CW-1:0]   m;
        logic [CW-1:0]        r;
        logic [2:0][CW-1:0]   bbp;
        logic [CW-1:0]        gap_len;
        logic [CW-1:0]        pen;
    } t_side;

    function automatic logic [CW-1:0] sat_mag(input logic neg, input logic [CW-1:0] mag);
        logic [CW-1:0] res;
        if (neg) begin
            if (mag > SIGN_BIT) res = SIGN_BIT;
            else res = ~mag + 1'b1;
        end else if (mag[CW-1]) begin
            res = ~SIGN_BIT;
        end else begin
            res = mag;
        end
        return res;
    endfunction

endpackage

// ----- design/spop_front.sv -----
// Reference shape store and the gap, square and overlap stages ahead of the root.
module spop_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_acc,
    input  spop_pkg::t_in_beat          i_in,
    output logic                        o_valid,
    output logic [spop_pkg::SQW-1:0]    o_rad,
    output spop_pkg::t_side             o_side
);

    logic                               r_ref_sph;
    logic signed [spop_pkg::CW-1:0]     r_ref_c [3];
    logic [spop_pkg::HW-1:0]            r_ref_h [3];

    logic signed [spop_pkg::CW-1:0]     pos [3];
    logic [spop_pkg::HW-1:0]            hv [3];
    logic signed [spop_pkg::DW-1:0]     p [3];
    logic signed [spop_pkg::DW-1:0]     c [3];
    logic signed [spop_pkg::DW-1:0]     rh [3];
    logic signed [spop_pkg::DW-1:0]     th [3];

    logic                               r_a_v, n_a_v;
    spop_pkg::t_ctl                     r_a_ctl, n_a_ctl;
    logic                               r_a_clamp, n_a_clamp;
    logic signed [spop_pkg::DW-1:0]     r_a_val [3], n_a_val [3];
    logic signed [spop_pkg::DW-1:0]     r_a_lo [3], n_a_lo [3];
    logic signed [spop_pkg::DW-1:0]     r_a_hi [3], n_a_hi [3];
    logic signed [spop_pkg::DW-1:0]     r_a_b [3], n_a_b [3];
    logic [spop_pkg::MW-1:0]            r_a_lim [3], n_a_lim [3];

    logic                               r_b_v;
    spop_pkg::t_ctl                     r_b_ctl;
    logic signed [spop_pkg::DW-1:0]     r_b_d [3], n_b_d [3];
    logic [spop_pkg::MW-1:0]            r_b_lim [3];
    logic signed [spop_pkg::DW-1:0]     cv [3];

    logic                               r_c_v;
    spop_pkg::t_ctl                     r_c_ctl;
    logic [spop_pkg::MW-1:0]            r_c_m [3], n_c_m [3];
    logic [2:0]                         r_c_neg, n_c_neg, r_c_pos, n_c_pos;
    logic [spop_pkg::MW-1:0]            r_c_lim [3];

    logic                               r_d_v;
    spop_pkg::t_kind                    r_d_kind;
    logic                               r_d_want;
    logic [2:0]                         r_d_in, n_d_in, r_d_lt, n_d_lt, r_d_fit, n_d_fit;
    logic [2:0]                         r_d_pos;
    logic [spop_pkg::MW-1:0]            r_d_over [3], n_d_over [3];
    spop_pkg::t_side                    r_d_side, n_d_side;

    logic                               r_e_v;
    spop_pkg::t_kind                    r_e_kind;
    logic                               r_e_want;
    logic [2:0]                         r_e_in, r_e_lt, r_e_fit;
    logic [spop_pkg::SQW-1:0]           r_e_sq [3], n_e_sq [3];
    logic [spop_pkg::SQW-1:0]           r_e_rr, n_e_rr;
    spop_pkg::t_side                    r_e_side, n_e_side;
    logic [1:0]                         best;

    logic                               r_f_v;
    spop_pkg::t_kind                    r_f_kind;
    logic                               r_f_want;
    logic [2:0]                         r_f_in, r_f_lt, r_f_fit;
    logic [spop_pkg::D2W-1:0]           r_f_d2, n_f_d2;
    logic [spop_pkg::SQW-1:0]           r_f_rr;
    spop_pkg::t_side                    r_f_side;

    logic                               r_g_v;
    logic [spop_pkg::SQW-1:0]           r_g_rad;
    spop_pkg::t_side                    r_g_side, n_g_side;
    logic                               g_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_sph <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ref_c[i] <= '0;
                r_ref_h[i] <= '0;
            end
        end else if (i_acc && i_in.cmd == spop_pkg::CMD_LOAD) begin
            r_ref_sph <= i_in.shape_is_sphere;
            r_ref_c[0] <= i_in.pos_x;
            r_ref_c[1] <= i_in.pos_y;
            r_ref_c[2] <= i_in.pos_z;
            r_ref_h[0] <= i_in.half_x;
            r_ref_h[1] <= i_in.half_y;
            r_ref_h[2] <= i_in.half_z;
        end
    end

    always_comb begin
        pos[0] = i_in.pos_x;
        pos[1] = i_in.pos_y;
        pos[2] = i_in.pos_z;
        hv[0]  = i_in.half_x;
        hv[1]  = i_in.half_y;
        hv[2]  = i_in.half_z;
        for (int i = 0; i < 3; i++) begin
            p[i]  = spop_pkg::DW'(pos[i]);
            c[i]  = spop_pkg::DW'(r_ref_c[i]);
            rh[i] = $signed(spop_pkg::DW'(r_ref_h[i]));
            th[i] = $signed(spop_pkg::DW'(hv[i]));
            n_a_val[i] = p[i];
            n_a_b[i]   = c[i];
            n_a_lo[i]  = c[i] - rh[i];
            n_a_hi[i]  = c[i] + rh[i];
            n_a_lim[i] = spop_pkg::MW'(r_ref_h[i]);
        end
        n_a_clamp      = 1'b0;
        n_a_ctl.coinc  = 1'b0;
        n_a_ctl.negate = 1'b0;
        n_a_ctl.want   = i_in.want_push && (i_in.cmd == spop_pkg::CMD_SHAPE);
        n_a_ctl.kind   = spop_pkg::KIND_PT_BOX;
        n_a_v = i_acc && (i_in.cmd == spop_pkg::CMD_SHAPE || i_in.cmd == spop_pkg::CMD_POINT);
        if (i_in.cmd == spop_pkg::CMD_POINT) begin
            n_a_ctl.kind = r_ref_sph ? spop_pkg::KIND_PT_SPH : spop_pkg::KIND_PT_BOX;
        end else begin
            case ({r_ref_sph, i_in.shape_is_sphere})
                2'b00: begin
                    n_a_ctl.kind = spop_pkg::KIND_BB;
                    for (int i = 0; i < 3; i++) begin
                        n_a_lim[i] = spop_pkg::MW'(r_ref_h[i]) + spop_pkg::MW'(hv[i]);
                    end
                end
                2'b11: begin
                    n_a_ctl.kind  = spop_pkg::KIND_SS;
                    n_a_ctl.coinc = 1'b1;
                    n_a_lim[0]    = spop_pkg::MW'(r_ref_h[0]) + spop_pkg::MW'(hv[0]);
                end
                2'b01: begin
                    n_a_ctl.kind   = spop_pkg::KIND_RBOX_TSPH;
                    n_a_ctl.negate = 1'b1;
                    n_a_clamp      = 1'b1;
                    n_a_lim[0]     = spop_pkg::MW'(hv[0]);
                    for (int i = 0; i < 3; i++) begin
                        n_a_b[i] = p[i];
                    end
                end
                default: begin
                    n_a_ctl.kind = spop_pkg::KIND_RSPH_TBOX;
                    n_a_clamp    = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_a_val[i] = c[i];
                        n_a_lo[i]  = p[i] - th[i];
                        n_a_hi[i]  = p[i] + th[i];
                    end
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cv[i] = r_a_val[i];
            if (r_a_clamp) begin
                if (cv[i] < r_a_lo[i]) cv[i] = r_a_lo[i];
                else if (cv[i] > r_a_hi[i]) cv[i] = r_a_hi[i];
            end
            n_b_d[i] = cv[i] - r_a_b[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_neg[i] = r_b_d[i][spop_pkg::DW-1];
            n_c_pos[i] = !r_b_d[i][spop_pkg::DW-1] && (r_b_d[i] != '0);
            n_c_m[i]   = r_b_d[i][spop_pkg::DW-1] ? spop_pkg::MW'(-r_b_d[i])
                                                  : spop_pkg::MW'(r_b_d[i]);
        end
    end

    always_comb begin
        n_d_side        = '0;
        n_d_side.coinc  = r_c_ctl.coinc;
        n_d_side.negate = r_c_ctl.negate;
        n_d_side.neg    = r_c_neg;
        n_d_side.r      = r_c_lim[0][spop_pkg::CW-1:0];
        for (int i = 0; i < 3; i++) begin
            n_d_in[i]     = r_c_m[i] <= r_c_lim[i];
            n_d_lt[i]     = r_c_m[i] < r_c_lim[i];
            n_d_fit[i]    = r_c_m[i] <= r_c_lim[0];
            n_d_over[i]   = r_c_lim[i] - r_c_m[i];
            n_d_side.m[i] = r_c_m[i][spop_pkg::CW-1:0];
        end
    end

    always_comb begin
        n_e_side = r_d_side;
        for (int i = 0; i < 3; i++) begin
            n_e_sq[i] = spop_pkg::SQW'(r_d_side.m[i]) * spop_pkg::SQW'(r_d_side.m[i]);
            n_e_side.bbp[i] = '0;
        end
        n_e_rr = spop_pkg::SQW'(r_d_side.r) * spop_pkg::SQW'(r_d_side.r);
        best = 2'd0;
        if (r_d_over[1] < r_d_over[0]) best = 2'd1;
        if (r_d_over[2] < r_d_over[best]) best = 2'd2;
        n_e_side.bbp[best] = spop_pkg::sat_mag(!r_d_pos[best],
                                               r_d_over[best][spop_pkg::CW-1:0]);
    end

    assign n_f_d2 = spop_pkg::D2W'(r_e_sq[0]) + spop_pkg::D2W'(r_e_sq[1])
                  + spop_pkg::D2W'(r_e_sq[2]);

    always_comb begin
        case (r_f_kind)
            spop_pkg::KIND_PT_BOX: g_hit = &r_f_in;
            spop_pkg::KIND_BB:     g_hit = &r_f_lt;
            default:               g_hit = (&r_f_fit) && (r_f_d2 <= spop_pkg::D2W'(r_f_rr));
        endcase
        n_g_side     = r_f_side;
        n_g_side.hit = g_hit;
        n_g_side.pv  = g_hit && r_f_want;
        n_g_side.sph = (r_f_kind != spop_pkg::KIND_BB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= n_a_v;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctl   <= n_a_ctl;
            r_a_clamp <= n_a_clamp;
            r_b_ctl   <= r_a_ctl;
            r_c_ctl   <= r_b_ctl;
            r_c_neg   <= n_c_neg;
            r_c_pos   <= n_c_pos;
            r_d_kind  <= r_c_ctl.kind;
            r_d_want  <= r_c_ctl.want;
            r_d_in    <= n_d_in;
            r_d_lt    <= n_d_lt;
            r_d_fit   <= n_d_fit;
            r_d_pos   <= r_c_pos;
            r_d_side  <= n_d_side;
            r_e_kind  <= r_d_kind;
            r_e_want  <= r_d_want;
            r_e_in    <= r_d_in;
            r_e_lt    <= r_d_lt;
            r_e_fit   <= r_d_fit;
            r_e_rr    <= n_e_rr;
            r_e_side  <= n_e_side;
            r_f_kind  <= r_e_kind;
            r_f_want  <= r_e_want;
            r_f_in    <= r_e_in;
            r_f_lt    <= r_e_lt;
            r_f_fit   <= r_e_fit;
            r_f_d2    <= n_f_d2;
            r_f_rr    <= r_e_rr;
            r_f_side  <= r_e_side;
            r_g_rad   <= r_f_d2[spop_pkg::SQW-1:0];
            r_g_side  <= n_g_side;
            for (int i = 0; i < 3; i++) begin
                r_a_val[i]  <= n_a_val[i];
                r_a_lo[i]   <= n_a_lo[i];
                r_a_hi[i]   <= n_a_hi[i];
                r_a_b[i]    <= n_a_b[i];
                r_a_lim[i]  <= n_a_lim[i];
                r_b_d[i]    <= n_b_d[i];
                r_b_lim[i]  <= r_a_lim[i];
                r_c_m[i]    <= n_c_m[i];
                r_c_lim[i]  <= r_b_lim[i];
                r_d_over[i] <= n_d_over[i];
                r_e_sq[i]   <= n_e_sq[i];
            end
        end
    end

    assign o_valid = r_g_v;
    assign o_rad   = r_g_rad;
    assign o_side  = r_g_side;

endmodule

// ----- design/spop_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module spop_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [spop_pkg::SQW-1:0]    i_rad,
    input  spop_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [spop_pkg::CW-1:0]     o_root,
    output spop_pkg::t_side             o_side
);

    logic                        r_v    [spop_pkg::SQ_STAGES];
    logic [spop_pkg::SQW-1:0]    r_rad  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::RW-1:0]     r_rem  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::CW-1:0]     r_root [spop_pkg::SQ_STAGES];
    spop_pkg::t_side             r_side [spop_pkg::SQ_STAGES];

    logic [spop_pkg::SQW-1:0]    s_rad  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::RW-1:0]     s_rem  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::CW-1:0]     s_root [spop_pkg::SQ_STAGES];
    logic [spop_pkg::RW-1:0]     t_rem  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::RW-1:0]     trial  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::RW-1:0]     n_rem  [spop_pkg::SQ_STAGES];
    logic [spop_pkg::CW-1:0]     n_root [spop_pkg::SQ_STAGES];

    always_comb begin
        s_rad[0]  = i_rad;
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int k = 1; k < spop_pkg::SQ_STAGES; k++) begin
            s_rad[k]  = r_rad[k-1];
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
        end
        for (int k = 0; k < spop_pkg::SQ_STAGES; k++) begin
            t_rem[k] = {s_rem[k][spop_pkg::RW-3:0], s_rad[k][spop_pkg::SQW-1 -: 2]};
            trial[k] = {1'b0, s_root[k], 2'b01};
            if (t_rem[k] >= trial[k]) begin
                n_rem[k]  = t_rem[k] - trial[k];
                n_root[k] = {s_root[k][spop_pkg::CW-2:0], 1'b1};
            end else begin
                n_rem[k]  = t_rem[k];
                n_root[k] = {s_root[k][spop_pkg::CW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < spop_pkg::SQ_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < spop_pkg::SQ_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < spop_pkg::SQ_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < spop_pkg::SQ_STAGES; k++) begin
                r_rad[k]  <= {s_rad[k][spop_pkg::SQW-3:0], 2'b00};
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_valid = r_v[spop_pkg::SQ_STAGES-1];
    assign o_root  = r_root[spop_pkg::SQ_STAGES-1];
    assign o_side  = r_side[spop_pkg::SQ_STAGES-1];

endmodule

// ----- design/spop_div.sv -----
// Pipelined three-lane restoring divider, one quotient bit per stage.
module spop_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][spop_pkg::SQW-1:0]   i_num,
    input  spop_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [2:0][spop_pkg::CW-1:0]    o_q,
    output spop_pkg::t_side                 o_side
);

    logic                            r_v    [spop_pkg::DIV_STAGES];
    logic [2:0][spop_pkg::CW-1:0]    r_rem  [spop_pkg::DIV_STAGES];
    logic [2:0][spop_pkg::CW-1:0]    r_lq   [spop_pkg::DIV_STAGES];
    spop_pkg::t_side                 r_side [spop_pkg::DIV_STAGES];

    logic [2:0][spop_pkg::CW-1:0]    s_rem  [spop_pkg::DIV_STAGES];
    logic [2:0][spop_pkg::CW-1:0]    s_lq   [spop_pkg::DIV_STAGES];
    logic [spop_pkg::CW-1:0]         s_den  [spop_pkg::DIV_STAGES];
    logic [2:0][spop_pkg::CW-1:0]    n_rem  [spop_pkg::DIV_STAGES];
    logic [2:0][spop_pkg::CW-1:0]    n_lq   [spop_pkg::DIV_STAGES];
    logic [spop_pkg::CW:0]           t_val;
    logic                            qbit;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            s_rem[0][j] = i_num[j][spop_pkg::SQW-1:spop_pkg::CW];
            s_lq[0][j]  = i_num[j][spop_pkg::CW-1:0];
        end
        s_den[0] = i_side.gap_len;
        for (int k = 1; k < spop_pkg::DIV_STAGES; k++) begin
            s_rem[k] = r_rem[k-1];
            s_lq[k]  = r_lq[k-1];
            s_den[k] = r_side[k-1].gap_len;
        end
        t_val = '0;
        qbit  = 1'b0;
        for (int k = 0; k < spop_pkg::DIV_STAGES; k++) begin
            for (int j = 0; j < 3; j++) begin
                t_val = {s_rem[k][j], s_lq[k][j][spop_pkg::CW-1]};
                qbit  = t_val >= {1'b0, s_den[k]};
                n_rem[k][j] = qbit ? spop_pkg::CW'(t_val - {1'b0, s_den[k]})
                                   : t_val[spop_pkg::CW-1:0];
                n_lq[k][j]  = {s_lq[k][j][spop_pkg::CW-2:0], qbit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < spop_pkg::DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < spop_pkg::DIV_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < spop_pkg::DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < spop_pkg::DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_lq[k]  <= n_lq[k];
            end
        end
    end

    assign o_valid = r_v[spop_pkg::DIV_STAGES-1];
    assign o_q     = r_lq[spop_pkg::DIV_STAGES-1];
    assign o_side  = r_side[spop_pkg::DIV_STAGES-1];

endmodule

// ----- design/shape_pair_overlap_push.sv -----
// Throughput: one beat per cycle while the output is not stalled. A test beat passes
// through 7 front stages, a 32-stage square root, two product stages, a 32-stage divider
// and the output register, all on one shared enable.
// A load beat updates the reference shape at once and gives no result.
// Reset is synchronous and active low; it clears the reference to a zero box and all valids.
module shape_pair_overlap_push (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  spop_pkg::t_in_beat      i_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output spop_pkg::t_out_beat     o_out
);

    `include "shape_pair_overlap_push_assert.svh"

    logic                               en;
    logic                               acc;

    logic                               w_front_v;
    logic [spop_pkg::SQW-1:0]           w_front_rad;
    spop_pkg::t_side                    w_front_side;

    logic                               w_sq_v;
    logic [spop_pkg::CW-1:0]            w_sq_root;
    spop_pkg::t_side                    w_sq_side;

    logic                               r_m1_v;
    spop_pkg::t_side                    r_m1_side, n_m1_side;
    logic                               r_m2_v;
    spop_pkg::t_side                    r_m2_side;
    logic [2:0][spop_pkg::SQW-1:0]      r_m2_num, n_m2_num;

    logic                               w_div_v;
    logic [2:0][spop_pkg::CW-1:0]       w_div_q;
    spop_pkg::t_side                    w_div_side;

    logic                               r_out_v;
    spop_pkg::t_out_beat                r_out, n_out;
    logic [spop_pkg::CW-1:0]            pj [3];
    logic [spop_pkg::CW-1:0]            zmag [3];
    logic                               zneg [3];

    assign en      = !(r_out_v && i_stall);
    assign acc     = i_valid && en;
    assign o_stall = !en;

    spop_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_in    (i_in),
        .o_valid (w_front_v),
        .o_rad   (w_front_rad),
        .o_side  (w_front_side)
    );

    spop_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_front_v),
        .i_rad   (w_front_rad),
        .i_side  (w_front_side),
        .o_valid (w_sq_v),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    always_comb begin
        n_m1_side         = w_sq_side;
        n_m1_side.gap_len = w_sq_root;
        n_m1_side.pen     = w_sq_side.r - w_sq_root;
        for (int j = 0; j < 3; j++) begin
            n_m2_num[j] = spop_pkg::SQW'(r_m1_side.m[j]) * spop_pkg::SQW'(r_m1_side.pen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_m1_v  <= w_sq_v;
            r_m2_v  <= r_m1_v;
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_side <= n_m1_side;
            r_m2_side <= r_m1_side;
            r_m2_num  <= n_m2_num;
            r_out     <= n_out;
        end
    end

    spop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m2_v),
        .i_num   (r_m2_num),
        .i_side  (r_m2_side),
        .o_valid (w_div_v),
        .o_q     (w_div_q),
        .o_side  (w_div_side)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (w_div_side.gap_len == '0) begin
                zmag[j] = w_div_side.coinc ? w_div_side.pen : '0;
                zneg[j] = w_div_side.coinc ^ w_div_side.negate;
            end else begin
                zmag[j] = w_div_q[j];
                zneg[j] = w_div_side.neg[j] ^ w_div_side.negate;
            end
            if (!w_div_side.pv) pj[j] = '0;
            else if (!w_div_side.sph) pj[j] = w_div_side.bbp[j];
            else pj[j] = spop_pkg::sat_mag(zneg[j], zmag[j]);
        end
        n_out.hit        = w_div_side.hit;
        n_out.push_valid = w_div_side.pv;
        n_out.push_x     = $signed(pj[0]);
        n_out.push_y     = $signed(pj[1]);
        n_out.push_z     = $signed(pj[2]);
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

    `SPOP_ASSERT_NOW(a_push_needs_hit, i_clk, i_rst_n,
        o_valid && o_out.push_valid, o_out.hit, "push without hit")
    `SPOP_ASSERT_NOW(a_no_push_zero, i_clk, i_rst_n, o_valid && !o_out.push_valid,
        (o_out.push_x == 0) && (o_out.push_y == 0) && (o_out.push_z == 0),
        "nonzero push without push_valid")
    `SPOP_ASSERT_NEXT(a_front_holds, i_clk, i_rst_n,
        w_front_v && !en, w_front_v, "front result lost under stall")

endmodule
